### rtl/slt_pkg.sv
// Shared types and constants for the sorted list table.
// Used by the channel interfaces, the entry memory and the sequencer.
package slt_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int DATA_W = 32;
  localparam int OP_W = 2;
  localparam int ST_W = 2;
  localparam int POS_W = 4;
  localparam int OCC_W = 5;

  typedef enum logic [OP_W-1:0] {
    OP_SEARCH = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_CMP,
    S_SH_RD,
    S_SH_WR,
    S_PUT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic we;
    logic [IDX_W-1:0] waddr;
    logic [DATA_W-1:0] wdata;
    logic [IDX_W-1:0] raddr;
  } ram_req_t;

endpackage

### rtl/slt_if.sv
// Valid/ready channel interfaces for commands and results.
// Depends on slt_pkg for the field widths.
interface slt_cmd_if import slt_pkg::*; ();
  logic valid;
  logic ready;
  logic [OP_W-1:0] operation;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, operation, value, input ready);
  modport sink (input valid, operation, value, output ready);
endinterface

interface slt_rsp_if import slt_pkg::*; ();
  logic valid;
  logic ready;
  logic [ST_W-1:0] status;
  logic [POS_W-1:0] position;
  logic [OCC_W-1:0] occupancy;

  modport source (output valid, status, position, occupancy, input ready);
  modport sink (input valid, status, position, occupancy, output ready);
endinterface

### rtl/slt_ram.sv
// Entry memory: one write port and one registered read port.
// Depends on slt_pkg for the request struct and depth.
module slt_ram import slt_pkg::*; (
  input  logic clk,
  input  ram_req_t req,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end

endmodule

### rtl/slt_ctrl.sv
// Sequencer that scans, shifts and updates the entry memory one entry at a time.
// Depends on slt_pkg and the channel interfaces; drives slt_ram.
module slt_ctrl import slt_pkg::*; (
  input  logic clk,
  input  logic rst,
  slt_cmd_if.sink cmd,
  slt_rsp_if.source rsp,
  output ram_req_t ram_req,
  input  logic [DATA_W-1:0] rdata
);

  state_t state, state_next;
  logic [OP_W-1:0] op_q, op_q_next;
  logic signed [DATA_W-1:0] value_q, value_q_next;
  logic [IDX_W-1:0] idx, idx_next;
  logic [IDX_W-1:0] ptr, ptr_next;
  logic [IDX_W-1:0] at, at_next;
  logic [CNT_W-1:0] count, count_next;
  logic [ST_W-1:0] status_q, status_q_next;
  logic [POS_W-1:0] pos_q, pos_q_next;
  logic last;
  logic is_insert;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
    op_q <= op_q_next;
    value_q <= value_q_next;
    idx <= idx_next;
    ptr <= ptr_next;
    at <= at_next;
    status_q <= status_q_next;
    pos_q <= pos_q_next;
  end

  assign last = ((CNT_W'(idx) + CNT_W'(1)) == count);
  assign is_insert = (op_q == OP_INSERT);

  always_comb begin
    state_next = state;
    op_q_next = op_q;
    value_q_next = value_q;
    idx_next = idx;
    ptr_next = ptr;
    at_next = at;
    count_next = count;
    status_q_next = status_q;
    pos_q_next = pos_q;
    ram_req.we = 1'b0;
    ram_req.waddr = ptr;
    ram_req.wdata = rdata;
    ram_req.raddr = idx;
    cmd.ready = (state == S_IDLE);
    rsp.valid = (state == S_DONE);
    rsp.status = status_q;
    rsp.position = pos_q;
    rsp.occupancy = OCC_W'(count);

    case (state)
      S_IDLE: begin
        if (cmd.valid) begin
          op_q_next = cmd.operation;
          value_q_next = cmd.value;
          idx_next = '0;
          pos_q_next = '0;
          case (cmd.operation)
            OP_SEARCH, OP_DELETE: begin
              if (count == '0) begin
                status_q_next = ST_EMPTY;
                state_next = S_DONE;
              end else begin
                state_next = S_READ;
              end
            end
            OP_INSERT: begin
              if (count == CNT_W'(CAPACITY)) begin
                status_q_next = ST_FULL;
                state_next = S_DONE;
              end else if (count == '0) begin
                at_next = '0;
                state_next = S_PUT;
              end else begin
                state_next = S_READ;
              end
            end
            default: begin
              status_q_next = ST_NOT_FOUND;
              state_next = S_DONE;
            end
          endcase
        end
      end
      S_READ: begin
        state_next = S_CMP;
      end
      S_CMP: begin
        if (is_insert) begin
          if ($signed(rdata) > value_q) begin
            at_next = idx;
            ptr_next = count[IDX_W-1:0];
            state_next = S_SH_RD;
          end else if (last) begin
            at_next = count[IDX_W-1:0];
            state_next = S_PUT;
          end else begin
            idx_next = idx + IDX_W'(1);
            state_next = S_READ;
          end
        end else if (rdata == value_q) begin
          status_q_next = ST_OK;
          pos_q_next = POS_W'(idx);
          if (op_q == OP_DELETE && !last) begin
            ptr_next = idx;
            state_next = S_SH_RD;
          end else begin
            if (op_q == OP_DELETE) begin
              count_next = count - CNT_W'(1);
            end
            state_next = S_DONE;
          end
        end else if (last) begin
          status_q_next = ST_NOT_FOUND;
          state_next = S_DONE;
        end else begin
          idx_next = idx + IDX_W'(1);
          state_next = S_READ;
        end
      end
      S_SH_RD: begin
        ram_req.raddr = is_insert ? (ptr - IDX_W'(1)) : (ptr + IDX_W'(1));
        state_next = S_SH_WR;
      end
      S_SH_WR: begin
        ram_req.we = 1'b1;
        if (is_insert) begin
          ptr_next = ptr - IDX_W'(1);
          state_next = ((ptr - IDX_W'(1)) == at) ? S_PUT : S_SH_RD;
        end else begin
          ptr_next = ptr + IDX_W'(1);
          if ((CNT_W'(ptr) + CNT_W'(2)) == count) begin
            count_next = count - CNT_W'(1);
            state_next = S_DONE;
          end else begin
            state_next = S_SH_RD;
          end
        end
      end
      S_PUT: begin
        ram_req.we = 1'b1;
        ram_req.waddr = at;
        ram_req.wdata = value_q;
        count_next = count + CNT_W'(1);
        status_q_next = ST_OK;
        pos_q_next = POS_W'(at);
        state_next = S_DONE;
      end
      S_DONE: begin
        if (rsp.ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

### rtl/sorted_list_table.sv
// Top level of the sorted list table: a sequencer and a 16-entry memory.
// Depends on slt_pkg, slt_if, slt_ram and slt_ctrl.
//
// Usage: commands arrive on the cmd channel (operation, value) and each one
// produces exactly one item on the rsp channel (status, position, occupancy).
// Operation 0 searches, 1 inserts in ascending signed order after any equal
// entries, 2 deletes the first equal entry. Code 3 changes nothing.
// The block works on one command at a time: cmd.ready is high only when it
// is idle, and it stays low until the result item has been taken.
// Timing: every stored entry examined takes a memory read state, then a
// compare state, and every entry moved by an insert or delete takes a read
// state, then a write-back state, through the memory's single read port. An
// insert adds a final state to write the new value. Rejections such as an
// empty or full table answer in the cycle after acceptance. When rsp.ready
// is high, the block goes from the result state back to idle and accepts
// the next command there.
// The result holds on rsp while rsp.ready is low; nothing else is lost.
// Reset (rst, synchronous) empties the table at once; memory contents are
// never read before they are written, so no clearing pass is needed.
module sorted_list_table import slt_pkg::*; (
  input  logic clk,
  input  logic rst,
  slt_cmd_if.sink cmd,
  slt_rsp_if.source rsp
);

  ram_req_t ram_req;
  logic [DATA_W-1:0] rdata;

  slt_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .rsp     (rsp),
    .ram_req (ram_req),
    .rdata   (rdata)
  );

  slt_ram u_ram (
    .clk   (clk),
    .req   (ram_req),
    .rdata (rdata)
  );

endmodule
